// ----- design/hmf_pkg.sv -----
// ----------------------------------------------------------------------------
// hmf_pkg - shared types and codes of the histogram median finder
// Opcode and status codes plus the fixed field widths of the request and
// result channels.
// ----------------------------------------------------------------------------
package hmf_pkg;

	localparam int unsigned OPCODE_W = 1;
	localparam int unsigned VALUE_W  = 7;
	localparam int unsigned MEDIAN_W = 7;
	localparam int unsigned STATUS_W = 1;
	localparam int unsigned POS_W    = 16;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [MEDIAN_W-1:0] median_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0]    pos_t;

	localparam opcode_t OP_ADD    = 1'b0;
	localparam opcode_t OP_FINISH = 1'b1;

	localparam status_t ST_OK    = 1'b0;
	localparam status_t ST_RANGE = 1'b1;

	localparam pos_t POS_MAX = '1;

endpackage

// ----- design/hmf_if.sv -----
// ----------------------------------------------------------------------------
// hmf_if - request and result channels of the histogram median finder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hmf_req_if;
	import hmf_pkg::*;

	logic    valid;
	logic    ready;
	opcode_t opcode;
	value_t  value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface hmf_res_if;
	import hmf_pkg::*;

	logic    valid;
	logic    ready;
	median_t median;
	status_t status;
	pos_t    bad_position;

	modport source (output valid, output median, output status, output bad_position,
		input ready);
	modport sink   (input valid, input median, input status, input bad_position,
		output ready);
endinterface

// ----- design/hmf_ram.sv -----
// ----------------------------------------------------------------------------
// hmf_ram - generic simple dual-port RAM
// One write port, one read port with registered data. A read and a write of
// the same entry at one edge return the old contents.
// ----------------------------------------------------------------------------
module hmf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 101
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/histogram_median_finder.sv -----
// ----------------------------------------------------------------------------
// histogram_median_finder - lower median of a sample set via a bin histogram
// Add requests bump one bin count in a RAM; a finish request sweeps all bins,
// reports the first bin whose running sum reaches (total+1)/2 and zeroes the
// histogram on the way.
// Flow: an add reads its bin with the request, then increments and writes back
//   in the next cycle; adds stream back to back while the result slot is free or
//   draining, and forwarding covers a repeat of the same bin. An out-of-range
//   add answers in the next cycle, a finish once the sweep has summed the last
//   bin; either keeps the request side busy while the bin sweep walks the RAM.
// Reset: arst_n clears control state, then a clearing sweep of all bins
//   zeroes the histogram before the first request is taken.
// ----------------------------------------------------------------------------
module histogram_median_finder #(
	parameter int unsigned NUM_BINS   = 101,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	hmf_req_if.sink          samples,
	hmf_res_if.source        results
);
	import hmf_pkg::*;

	localparam int unsigned AW = $clog2(NUM_BINS);
	localparam int unsigned CW = COUNT_BITS;

	localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);
	localparam logic [CW-1:0] CNT_MAX  = '1;

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_TAIL  = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] addr_q;        // sweep read/clear pointer
	logic          clr_only_q;    // sweep only zeroes bins, no median
	logic [CW-1:0] total_q;       // samples in the current set
	logic [CW-1:0] thr_q;         // (total+1)/2 latched at finish
	logic [CW:0]   running_q;     // running bin sum during the sweep
	logic          found_q;
	logic [AW-1:0] med_q;

	// Stage 1: RAM data is back for the entry read in the previous cycle
	logic          add_vld_s1;
	logic          swp_vld_s1;
	logic          swp_last_s1;
	logic [AW-1:0] addr_s1;

	// Copy of the add write done at the last edge, for read-after-write forwarding
	logic          fwd_vld_q;
	logic [AW-1:0] fwd_addr_q;
	logic [CW-1:0] fwd_data_q;

	// Result register
	logic    out_vld_q;
	median_t out_median_q;
	status_t out_status_q;
	pos_t    out_pos_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [CW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [CW-1:0] ram_rdata;

	logic          req_fire;
	logic          req_bad;
	logic [AW-1:0] req_bin;
	logic [CW-1:0] bin_cur;
	logic [CW-1:0] bin_inc;
	logic [CW:0]   sum_w;
	logic          hit;
	logic [CW:0]   pos_w;
	pos_t          bad_pos;

	// ------------------------------------------------------------------
	// Request side: take a request only when idle and the result slot is
	// free or draining this cycle.
	// ------------------------------------------------------------------
	assign samples.ready = (state_q == S_IDLE) && (!out_vld_q || results.ready);
	assign req_fire      = samples.valid && samples.ready;
	assign req_bad       = (32'(samples.value) > 32'(NUM_BINS - 1));
	assign req_bin       = AW'(samples.value);

	// 1-based position of a bad sample, clipped to the field width
	assign pos_w   = {1'b0, total_q} + (CW+1)'(1);
	assign bad_pos = ((CW+1 > POS_W) && (pos_w > (CW+1)'(POS_MAX))) ? POS_MAX
		: POS_W'(pos_w);

	// ------------------------------------------------------------------
	// Histogram RAM: sweep reads and zeroes the same entry at one edge (the
	// read returns the old count); adds write back in stage 1.
	// ------------------------------------------------------------------
	assign ram_raddr = (state_q == S_SWEEP) ? addr_q : req_bin;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = bin_inc;
		if (state_q == S_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = '0;
		end else if (add_vld_s1) begin
			ram_we = 1'b1;
		end
	end

	hmf_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Forward the previous write when it hit the entry read at that edge
	assign bin_cur = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
	assign bin_inc = (bin_cur == CNT_MAX) ? CNT_MAX : bin_cur + CW'(1);

	// Median search on the swept entry; stop summing once found, so the
	// running sum stays below threshold plus one count
	assign sum_w = running_q + {1'b0, ram_rdata};
	assign hit   = !found_q && (sum_w >= {1'b0, thr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			addr_q      <= '0;
			clr_only_q  <= 1'b1;
			total_q     <= '0;
			running_q   <= '0;
			found_q     <= 1'b0;
			add_vld_s1  <= 1'b0;
			swp_vld_s1  <= 1'b0;
			swp_last_s1 <= 1'b0;
			fwd_vld_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			add_vld_s1  <= 1'b0;
			swp_vld_s1  <= 1'b0;
			swp_last_s1 <= 1'b0;
			fwd_vld_q   <= add_vld_s1 && (state_q != S_SWEEP);

			// Drop the result once taken; a new load below wins
			if (results.valid && results.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (samples.opcode == OP_FINISH) begin
							state_q    <= S_SWEEP;
							addr_q     <= '0;
							clr_only_q <= 1'b0;
							total_q    <= '0;
							running_q  <= '0;
							found_q    <= 1'b0;
						end else if (req_bad) begin
							// Abort the set: report now, then wipe the bins
							state_q    <= S_SWEEP;
							addr_q     <= '0;
							clr_only_q <= 1'b1;
							total_q    <= '0;
							out_vld_q  <= 1'b1;
						end else begin
							add_vld_s1 <= 1'b1;
							total_q    <= (total_q == CNT_MAX) ? CNT_MAX
								: total_q + CW'(1);
						end
					end
				end
				S_SWEEP: begin
					swp_vld_s1  <= 1'b1;
					swp_last_s1 <= (addr_q == LAST_BIN);
					if (addr_q == LAST_BIN) begin
						state_q <= S_TAIL;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_TAIL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Stage 1 of the sweep: advance the running sum
			if (swp_vld_s1 && !clr_only_q) begin
				if (hit) begin
					found_q <= 1'b1;
				end
				if (!found_q) begin
					running_q <= sum_w;
				end
				if (swp_last_s1) begin
					out_vld_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			addr_s1 <= req_bin;
			thr_q   <= CW'(pos_w >> 1);
			med_q   <= '0;
			if ((samples.opcode == OP_ADD) && req_bad) begin
				out_median_q <= '0;
				out_status_q <= ST_RANGE;
				out_pos_q    <= bad_pos;
			end
		end
		if (state_q == S_SWEEP) begin
			addr_s1 <= addr_q;
		end
		if (add_vld_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= bin_inc;
		end
		if (swp_vld_s1 && !clr_only_q) begin
			if (hit) begin
				med_q <= addr_s1;
			end
			if (swp_last_s1) begin
				out_median_q <= MEDIAN_W'(hit ? addr_s1 : med_q);
				out_status_q <= ST_OK;
				out_pos_q    <= '0;
			end
		end
	end

	assign results.valid        = out_vld_q;
	assign results.median       = out_median_q;
	assign results.status       = out_status_q;
	assign results.bad_position = out_pos_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_no_add_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(add_vld_s1 && (state_q == S_SWEEP)))
		else $error("add write-back overlaps the bin sweep");

	a_bad_value_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (samples.opcode == OP_ADD) && req_bad)
		|=> (results.valid && (results.status == ST_RANGE)))
		else $error("out-of-range sample gave no error result");

	a_finish_reports: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_TAIL) && !clr_only_q)
		|=> (results.valid && (results.status == ST_OK)))
		else $error("finished sweep gave no median result");

	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && ((samples.opcode == OP_FINISH) || req_bad)) |=> (total_q == '0))
		else $error("sample total not cleared at end of set");

	a_idle_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		swp_last_s1 |-> (state_q == S_TAIL))
		else $error("sweep tail out of step with the sequencer");

endmodule

// ----- verif/tb_histogram_median_finder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_histogram_median_finder - self-checking bench of the histogram median finder
// Drives add and finish requests over the request channel and predicts every
// median or range-error result with its own histogram model. Results are
// checked in order, field by field. Both channels idle at random: bursty
// requests, patterned result stalls. A directed opener covers the corner
// cases and random sets follow.
// ----------------------------------------------------------------------------
module tb_histogram_median_finder;
	import hmf_pkg::*;

	localparam int unsigned NUM_BINS        = 101;
	localparam int unsigned COUNT_BITS      = 16;
	localparam int unsigned HALF_PERIOD     = 2;
	localparam int unsigned RESET_CYCLES    = 5;
	localparam int unsigned RANDOM_REQUESTS = 1250;
	// no-progress limit: clearing sweep, finish sweep and the longest result stall fit
	// many times over
	localparam int unsigned IDLE_LIMIT      = 4000;
	// a finish answers only once its bin sweep is done; the drain wait leaves room past that
	localparam int unsigned DRAIN_CYCLES    = NUM_BINS + 20;
	localparam int unsigned MAX_REPORTS     = 40;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		median_t median;
		status_t status;
		pos_t    bad_position;
	} median_result_t;

	// Histogram predictor and in-order store of the medians and range errors to come.
	class median_scoreboard;
		count_t         bin_count [NUM_BINS];
		count_t         sample_total;
		median_result_t expected_q [$];
		int unsigned    mismatches;

		function new();
			mismatches = 0;
			clear_set();
		endfunction

		function void clear_set();
			foreach (bin_count[i]) bin_count[i] = '0;
			sample_total = '0;
		endfunction

		function count_t bump(count_t c);
			return (&c) ? c : c + 1'b1;
		endfunction

		// Update the histogram with one accepted request; queue the result it causes.
		function void note_request(opcode_t op, value_t v);
			median_result_t          r;
			logic [COUNT_BITS:0]     threshold;
			logic [COUNT_BITS:0]     next_pos;
			logic [COUNT_BITS+12:0]  running;
			r = '0;
			if (op == OP_ADD) begin
				if (v <= NUM_BINS - 1) begin
					bin_count[v] = bump(bin_count[v]);
					sample_total = bump(sample_total);
					return;
				end
				next_pos = {1'b0, sample_total} + 1'b1;
				r.status = ST_RANGE;
				r.bad_position = (next_pos > POS_MAX) ? POS_MAX : pos_t'(next_pos);
			end else begin
				threshold = ({1'b0, sample_total} + 1'b1) >> 1;
				running = '0;
				r.status = ST_OK;
				for (int b = 0; b < NUM_BINS; b++) begin
					running += bin_count[b];
					if (running >= threshold) begin
						r.median = median_t'(b);
						break;
					end
				end
			end
			clear_set();
			expected_q.push_back(r);
		endfunction

		task report(string what);
			if (mismatches < MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(median_t m, status_t s, pos_t p);
			median_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing pending: median=%0d status=%0d pos=%0d",
					m, s, p));
				return;
			end
			e = expected_q.pop_front();
			if (m !== e.median)
				report($sformatf("median %0d, want %0d", m, e.median));
			if (s !== e.status)
				report($sformatf("status %0d, want %0d", s, e.status));
			if (p !== e.bad_position)
				report($sformatf("bad_position %0d, want %0d", p, e.bad_position));
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hmf_req_if samples_if ();
	hmf_res_if results_if ();

	median_scoreboard board = new();

	int unsigned burst_left   = 0;
	int unsigned ready_mode   = 0;
	int unsigned ready_left   = 0;
	logic [7:0]  ready_pattern = 8'h01;
	int unsigned idle_cycles  = 0;

	histogram_median_finder #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Send one request and hold it until the block takes it. Requests come in bursts;
	// at the start of each burst, drop valid for a random gap (often none at all).
	task automatic send_request(opcode_t op, value_t v);
		int unsigned gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				9:          gap = $urandom_range(5, 20);
				default:    gap = $urandom_range(1, 4);
			endcase
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				samples_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		samples_if.valid  <= 1'b1;
		samples_if.opcode <= op;
		samples_if.value  <= v;
		// ready is sampled as it stood at the edge, so the request is taken here
		do @(posedge clk); while (samples_if.ready !== 1'b1);
		board.note_request(op, v);
	endtask

	// Corner cases: empty set, both ends of the bin range, out-of-range values at
	// the head and inside a set, lower median of an even set, odd set, repeats of
	// one bin back to back, and a finish carrying a nonzero (ignored) value.
	task automatic run_directed();
		send_request(OP_FINISH, 7'd0);
		send_request(OP_ADD, 7'd0);
		send_request(OP_FINISH, 7'd127);
		send_request(OP_ADD, 7'd100);
		send_request(OP_FINISH, 7'd0);
		send_request(OP_ADD, 7'd101);
		send_request(OP_ADD, 7'd5);
		send_request(OP_ADD, 7'd7);
		send_request(OP_ADD, 7'd127);
		send_request(OP_ADD, 7'd10);
		send_request(OP_ADD, 7'd20);
		send_request(OP_FINISH, 7'd0);
		send_request(OP_ADD, 7'd30);
		send_request(OP_ADD, 7'd10);
		send_request(OP_ADD, 7'd20);
		send_request(OP_FINISH, 7'd85);
		send_request(OP_ADD, 7'd42);
		send_request(OP_ADD, 7'd42);
		send_request(OP_ADD, 7'd42);
		send_request(OP_ADD, 7'd7);
		send_request(OP_FINISH, 7'd0);
		send_request(OP_ADD, 7'd64);
		send_request(OP_ADD, 7'd127);
	endtask

	// Random sets: mostly short, now and then long. Sample values are spread over
	// all bins, packed in a narrow window, stuck at the two ends or mixed. A few
	// sets abort on an out-of-range value; a few run on without a finish.
	task automatic run_random_sets();
		int unsigned sent;
		int unsigned set_len;
		int unsigned style;
		int unsigned lo;
		int unsigned hi;
		value_t      v;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			style = $urandom_range(0, 3);
			lo = $urandom_range(0, NUM_BINS - 1);
			hi = lo + $urandom_range(0, 6);
			if (hi > NUM_BINS - 1)
				hi = NUM_BINS - 1;
			set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150)
				: $urandom_range(0, 14);
			for (int i = 0; i < set_len; i++) begin
				if ($urandom_range(0, 59) == 0)
					v = value_t'($urandom_range(NUM_BINS, 127));
				else begin
					case (style)
						0:       v = value_t'($urandom_range(0, NUM_BINS - 1));
						1:       v = value_t'($urandom_range(lo, hi));
						2:       v = ($urandom_range(0, 1) != 0) ? value_t'(NUM_BINS - 1) : '0;
						default: v = ($urandom_range(0, 1) != 0) ? value_t'($urandom_range(lo, hi))
							: value_t'($urandom_range(0, NUM_BINS - 1));
					endcase
				end
				send_request(OP_ADD, v);
				sent++;
			end
			if ($urandom_range(0, 9) != 0) begin
				send_request(OP_FINISH, value_t'($urandom));
				sent++;
			end
		end
	endtask

	// Result side: check every accepted result, then pick the next ready level.
	// The stall pattern changes mode each time a randomly drawn run ends: always ready, mostly
	// ready, a rotating bit pattern, or mostly stalled.
	always @(posedge clk) begin
		if (results_if.valid === 1'b1 && results_if.ready === 1'b1)
			board.check_result(results_if.median, results_if.status, results_if.bad_position);
		if (ready_left == 0) begin
			ready_mode    = $urandom_range(0, 3);
			ready_left    = $urandom_range(16, 96);
			ready_pattern = 8'($urandom) | 8'h01;
		end
		ready_left--;
		ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
		case (ready_mode)
			0:       results_if.ready <= 1'b1;
			1:       results_if.ready <= ($urandom_range(0, 3) != 0);
			2:       results_if.ready <= ready_pattern[0];
			default: results_if.ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// Watchdog: end the run if no request or result moves for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (samples_if.valid === 1'b1 && samples_if.ready === 1'b1)
				|| (results_if.valid === 1'b1 && results_if.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** histogram_median_finder: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// hold every input at a known level through reset
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.opcode = OP_ADD;
		samples_if.value  = '0;
		results_if.ready  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// the block runs its clearing sweep first; send_request just waits on ready
		run_directed();
		run_random_sets();
		// drop valid at the edge that took the last request
		samples_if.valid <= 1'b0;

		// drain: every expected result in, then let any late extra result show up
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0) begin
			$display("** histogram_median_finder: PASSED **");
		end else begin
			$display("** histogram_median_finder: FAILED **");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/hmf_pkg.sv
design/hmf_if.sv
design/hmf_ram.sv
design/histogram_median_finder.sv
verif/tb_histogram_median_finder.sv
